@@ hdl/key_slot_registry_top_defines.svh @@
// ----------------------------------------------------------------------------
// Key slot registry assertion macros
// Shared assertion forms for the checker of the key slot registry.
// ----------------------------------------------------------------------------
`ifndef KEY_SLOT_REGISTRY_TOP_DEFINES_SVH
`define KEY_SLOT_REGISTRY_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled while reset is asserted.
`define KSR_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and disabled while reset is asserted.
`define KSR_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hdl/ksr_pkg.sv @@
// ----------------------------------------------------------------------------
// Key slot registry package
// Table size, field widths, operation and status codes, and the command
// bundle that the controller sends to the datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ksr_pkg;

	localparam int NUM_SLOTS    = 64;
	localparam int SLOT_W       = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int KEY_W        = 64;
	localparam int SLOT_FIELD_W = 6;
	localparam int OUT_TDATA_W  = 8;

	typedef enum logic [1:0] {
		OP_FIND   = 2'd0,
		OP_ADD    = 2'd1,
		OP_REMOVE = 2'd2,
		OP_RSVD   = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		STAT_FOUND     = 3'd0,
		STAT_ALLOCATED = 3'd1,
		STAT_NOT_FOUND = 3'd2,
		STAT_FULL      = 3'd3,
		STAT_REMOVED   = 3'd4
	} status_t;

	typedef struct packed {
		logic load;     // capture the accepted item
		logic compare;  // compare the item key against every slot
		logic commit;   // resolve, update the table and load the result
	} ksr_cmd_t;

	// Index of the lowest set bit; zero when no bit is set.
	function automatic logic [SLOT_W-1:0] lowest_index(input logic [NUM_SLOTS-1:0] vec);
		logic [SLOT_W-1:0] idx;
		idx = '0;
		for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
			if (vec[i]) begin
				idx = SLOT_W'(i);
			end
		end
		return idx;
	endfunction

endpackage

`default_nettype wire

@@ hdl/ksr_ctrl.sv @@
// ----------------------------------------------------------------------------
// Key slot registry controller
// Sequences each item through a compare state and a resolve state and owns
// the input ready and the output valid.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ksr_ctrl
	import ksr_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  wire logic     out_ready,
	output ksr_cmd_t      cmd
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_CMP  = 3'b010,
		ST_RES  = 3'b100
	} state_t;

	state_t state_q;
	state_t state_nxt;
	logic   out_valid_q;
	logic   out_free;

	// The output register can take a new result when empty or being drained.
	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		in_ready  = 1'b0;
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_nxt = ST_CMP;
				end
			end
			ST_CMP: begin
				state_nxt = ST_RES;
			end
			ST_RES: begin
				in_ready = out_free;
				if (out_free) begin
					state_nxt = in_valid ? ST_CMP : ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	assign cmd.load    = in_valid && in_ready;
	assign cmd.compare = (state_q == ST_CMP);
	assign cmd.commit  = (state_q == ST_RES) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

@@ hdl/ksr_datapath.sv @@
// ----------------------------------------------------------------------------
// Key slot registry datapath
// Holds the key table and slot valid bits, compares a key against all slots
// in parallel and resolves the request into a table update and a result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ksr_datapath
	import ksr_pkg::*;
(
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire ksr_cmd_t                cmd,
	input  wire logic [1:0]              req_type,
	input  wire logic [KEY_W-1:0]        key,
	output logic      [SLOT_FIELD_W-1:0] slot,
	output logic      [2:0]              status
);

	logic [KEY_W-1:0]        key_q [NUM_SLOTS];
	logic [NUM_SLOTS-1:0]    valid_q;

	op_t                     op_s1;
	logic [KEY_W-1:0]        key_s1;
	logic [NUM_SLOTS-1:0]    hit_s2;
	logic [NUM_SLOTS-1:0]    free_s2;

	logic [SLOT_FIELD_W-1:0] slot_q;
	status_t                 status_q;

	logic [NUM_SLOTS-1:0]    hit_vec;
	logic [SLOT_W-1:0]       hit_idx;
	logic [SLOT_W-1:0]       free_idx;
	logic                    hit_any;
	logic                    free_any;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_s1  <= op_t'(req_type);
			key_s1 <= key;
		end
	end

	// Every slot compares against the held key at once.
	always_comb begin
		for (int i = 0; i < NUM_SLOTS; i++) begin
			hit_vec[i] = valid_q[i] && (key_q[i] == key_s1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.compare) begin
			hit_s2  <= hit_vec;
			free_s2 <= ~valid_q;
		end
	end

	assign hit_idx  = lowest_index(hit_s2);
	assign free_idx = lowest_index(free_s2);
	assign hit_any  = |hit_s2;
	assign free_any = |free_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (cmd.commit) begin
			if (op_s1 == OP_ADD && !hit_any && free_any) begin
				valid_q[free_idx] <= 1'b1;
			end else if (op_s1 == OP_REMOVE && hit_any) begin
				valid_q[hit_idx] <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit && op_s1 == OP_ADD && !hit_any && free_any) begin
			key_q[free_idx] <= key_s1;
		end
	end

	// Keys are unique in the table, so the lowest hit is the only hit.
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			case (op_s1)
				OP_ADD: begin
					if (hit_any) begin
						slot_q   <= SLOT_FIELD_W'(hit_idx);
						status_q <= STAT_FOUND;
					end else if (free_any) begin
						slot_q   <= SLOT_FIELD_W'(free_idx);
						status_q <= STAT_ALLOCATED;
					end else begin
						slot_q   <= '0;
						status_q <= STAT_FULL;
					end
				end
				OP_REMOVE: begin
					if (hit_any) begin
						slot_q   <= SLOT_FIELD_W'(hit_idx);
						status_q <= STAT_REMOVED;
					end else begin
						slot_q   <= '0;
						status_q <= STAT_NOT_FOUND;
					end
				end
				default: begin
					if (hit_any) begin
						slot_q   <= SLOT_FIELD_W'(hit_idx);
						status_q <= STAT_FOUND;
					end else begin
						slot_q   <= '0;
						status_q <= STAT_NOT_FOUND;
					end
				end
			endcase
		end
	end

	assign slot   = slot_q;
	assign status = status_q;

endmodule

`default_nettype wire

@@ hdl/key_slot_registry_top.sv @@
// ----------------------------------------------------------------------------
// Key slot registry
// Associative table of 64-bit keys with find, add into the lowest free slot,
// and remove.
//
// Channel   Direction  tdata            tuser
// s_axis    in         key[63:0]        req_type[1:0]
// m_axis    out        slot[5:0], pad   status[2:0]
//
// Each item has a compare step, which checks its key against every slot in
// parallel, and a resolve step, which priority-encodes hits and free slots and
// updates the table; a new item is taken in any resolve step that commits.
// Reset clears all slot valid bits at once; the key table needs no clearing.
// A result waits in the output register; the next item is compared meanwhile
// and held in its resolve state until that register drains.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module key_slot_registry_top
	import ksr_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   s_axis_tvalid,
	output logic                        s_axis_tready,
	input  wire logic [KEY_W-1:0]       s_axis_tdata,   // key[63:0]
	input  wire logic [1:0]             s_axis_tuser,   // req_type[1:0]
	output logic                        m_axis_tvalid,
	input  wire logic                   m_axis_tready,
	output logic      [OUT_TDATA_W-1:0] m_axis_tdata,   // slot[5:0], zero [7:6]
	output logic      [2:0]             m_axis_tuser    // status[2:0]
);

	ksr_cmd_t                cmd;
	logic [SLOT_FIELD_W-1:0] slot;

	ksr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.cmd       (cmd)
	);

	ksr_datapath u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.req_type (s_axis_tuser),
		.key      (s_axis_tdata),
		.slot     (slot),
		.status   (m_axis_tuser)
	);

	assign m_axis_tdata = {{(OUT_TDATA_W - SLOT_FIELD_W){1'b0}}, slot};

endmodule

`default_nettype wire

@@ hdl/ksr_checker.sv @@
// ----------------------------------------------------------------------------
// Key slot registry checker
// Port-level assertions on the result stream of the key slot registry.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "key_slot_registry_top_defines.svh"

module ksr_checker
	import ksr_pkg::*;
(
	input wire logic                   clk,
	input wire logic                   arst_n,
	input wire logic                   m_axis_tvalid,
	input wire logic                   m_axis_tready,
	input wire logic [OUT_TDATA_W-1:0] m_axis_tdata,
	input wire logic [2:0]             m_axis_tuser
);

	`KSR_ASSERT_NEXT(a_valid_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "result dropped while stalled")
	`KSR_ASSERT_NEXT(a_data_hold, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata) && $stable(m_axis_tuser), "result changed while stalled")
	`KSR_ASSERT_NOW(a_status_range, m_axis_tvalid, m_axis_tuser <= STAT_REMOVED, "status code out of range")
	`KSR_ASSERT_NOW(a_no_slot_zero, m_axis_tvalid && (m_axis_tuser == STAT_NOT_FOUND || m_axis_tuser == STAT_FULL), m_axis_tdata == '0, "slot not zero on miss or full")

endmodule

bind key_slot_registry_top ksr_checker u_ksr_checker (.*);

`default_nettype wire
